// File: src/sjf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sjf_pkg;

  localparam int ID_W       = 16;
  localparam int BURST_IN_W = 16;
  localparam int WAIT_W     = 20;
  localparam int TAT_W      = 20;
  localparam int TW_W       = 23;
  localparam int TT_W       = 24;
  localparam int AVGW_W     = 27;
  localparam int AVGT_W     = 28;
  localparam int FRAC_W     = 8;

  typedef struct packed {
    logic busy;
    logic done;
  } sjf_div_stat_t;

endpackage

`default_nettype wire

// File: src/sjf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sjf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/sjf_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sjf_div #(
  parameter int DVD_W = 34,
  parameter int DVS_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [DVD_W-1:0] quotient,
  output sjf_pkg::sjf_div_stat_t stat
);

  import sjf_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign shifted  = {rem, quo[DVD_W-1]};
  assign ge       = shifted >= {1'b0, dvs};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;
  assign stat     = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        quo  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= CW'(DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/shortest_job_first_schedule.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: one entry per cycle while in_stall is low; the final entry closes the set.
// Schedule: each of the n rows scans the entry RAM (S_SCAN, S_DRAIN) for the smallest
// unused burst, forms the row in S_ROW and hands it off in S_EMIT once out_stall is low.
// The final row adds two serial divisions of TOTAL+8 bits before it is handed off.
// No new entry is taken until the final row has been handed off.
// rst (synchronous) empties the set and clears the drop flag and the output handshake.

module shortest_job_first_schedule #(
  parameter int MAX_PROCS  = 16,
  parameter int BURST_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [sjf_pkg::ID_W-1:0]        proc_id,
  input  wire logic [sjf_pkg::BURST_IN_W-1:0]  burst_time,
  input  wire logic                            final_entry,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [sjf_pkg::ID_W-1:0]        sched_id,
  output logic      [sjf_pkg::BURST_IN_W-1:0]  sched_burst,
  output logic      [sjf_pkg::WAIT_W-1:0]      wait_time,
  output logic      [sjf_pkg::TAT_W-1:0]       turnaround,
  output logic      [sjf_pkg::TW_W-1:0]        total_wait,
  output logic      [sjf_pkg::TT_W-1:0]        total_turnaround,
  output logic      [sjf_pkg::AVGW_W-1:0]      avg_wait,
  output logic      [sjf_pkg::AVGT_W-1:0]      avg_turnaround,
  output logic                                 overflowed,
  output logic                                 row_last
);

  import sjf_pkg::*;

  localparam int SB    = (BURST_BITS < BURST_IN_W) ? BURST_BITS : BURST_IN_W;
  localparam int LOG_N = $clog2(MAX_PROCS + 1);
  localparam int CNT_W = LOG_N;
  localparam int AW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int WT_W  = (SB + LOG_N > WAIT_W) ? SB + LOG_N : WAIT_W;
  localparam int TOT_W = (SB + 2 * LOG_N > TT_W) ? SB + 2 * LOG_N : TT_W;
  localparam int DVD_W = TOT_W + FRAC_W;
  localparam int RAM_W = ID_W + SB;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_ROW,
    S_DIVW,
    S_DIVT,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] n_reg;
  logic [CNT_W-1:0] k;
  logic             drop;
  logic [MAX_PROCS-1:0] used;
  logic [AW-1:0]    scan_i;
  logic [AW-1:0]    rd_idx;
  logic [AW-1:0]    best_idx;
  logic [AW-1:0]    last_idx;
  logic             rd_vld;
  logic             best_vld;
  logic [ID_W-1:0]  best_id;
  logic [SB-1:0]    best_burst;
  logic [WT_W-1:0]  wait_acc;
  logic [WT_W-1:0]  tat_now;
  logic [TOT_W-1:0] tw_acc;
  logic [TOT_W-1:0] tt_acc;
  logic [TOT_W-1:0] tw_next;
  logic [TOT_W-1:0] tt_next;
  logic             div_start;
  sjf_div_stat_t    div_stat;
  logic [DVD_W-1:0] div_dvd;
  logic [DVD_W-1:0] div_quo;
  logic             accept;
  logic             room;
  logic             row_is_last;
  logic             ram_we;
  logic [RAM_W-1:0] ram_wdata;
  logic [RAM_W-1:0] ram_rdata;
  logic [ID_W-1:0]  rd_id;
  logic [SB-1:0]    rd_burst;

  assign in_stall    = (state != S_LOAD);
  assign accept      = in_valid && !in_stall;
  assign room        = (cnt != CNT_W'(MAX_PROCS));
  assign cnt_inc     = cnt + CNT_W'(1);
  assign ram_we      = accept && room;
  assign ram_wdata   = {proc_id, burst_time[SB-1:0]};
  assign rd_id       = ram_rdata[RAM_W-1:SB];
  assign rd_burst    = ram_rdata[SB-1:0];
  assign last_idx    = AW'(n_reg - CNT_W'(1));
  assign row_is_last = ((k + CNT_W'(1)) == n_reg);
  assign tat_now     = wait_acc + WT_W'(best_burst);
  assign tw_next     = tw_acc + TOT_W'(wait_acc);
  assign tt_next     = tt_acc + TOT_W'(tat_now);
  assign div_dvd     = (state == S_DIVT) ? {tt_acc, {FRAC_W{1'b0}}}
                                         : {tw_acc, {FRAC_W{1'b0}}};

  sjf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_PROCS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (scan_i),
    .rdata (ram_rdata)
  );

  sjf_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (n_reg),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      drop      <= 1'b0;
      used      <= '0;
      k         <= '0;
      scan_i    <= '0;
      rd_vld    <= 1'b0;
      best_vld  <= 1'b0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              cnt <= cnt_inc;
            end else begin
              drop <= 1'b1;
            end
            if (final_entry) begin
              n_reg    <= room ? cnt_inc : cnt;
              used     <= '0;
              k        <= '0;
              scan_i   <= '0;
              best_vld <= 1'b0;
              wait_acc <= '0;
              tw_acc   <= '0;
              tt_acc   <= '0;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_idx <= scan_i;
          rd_vld <= 1'b1;
          if (scan_i == last_idx) begin
            state <= S_DRAIN;
          end else begin
            scan_i <= scan_i + AW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_ROW;
        end
        S_ROW: begin
          used[best_idx]   <= 1'b1;
          sched_id         <= best_id;
          sched_burst      <= BURST_IN_W'(best_burst);
          wait_time        <= wait_acc[WAIT_W-1:0];
          turnaround       <= tat_now[TAT_W-1:0];
          total_wait       <= tw_next[TW_W-1:0];
          total_turnaround <= tt_next[TT_W-1:0];
          avg_wait         <= '0;
          avg_turnaround   <= '0;
          overflowed       <= drop;
          row_last         <= row_is_last;
          tw_acc           <= tw_next;
          tt_acc           <= tt_next;
          if (row_is_last) begin
            div_start <= 1'b1;
            state     <= S_DIVW;
          end else begin
            out_valid <= 1'b1;
            state     <= S_EMIT;
          end
        end
        S_DIVW: begin
          div_start <= 1'b0;
          if (div_stat.done && !div_stat.busy) begin
            avg_wait  <= div_quo[AVGW_W-1:0];
            div_start <= 1'b1;
            state     <= S_DIVT;
          end
        end
        S_DIVT: begin
          div_start <= 1'b0;
          if (div_stat.done && !div_stat.busy) begin
            avg_turnaround <= div_quo[AVGT_W-1:0];
            out_valid      <= 1'b1;
            state          <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            wait_acc  <= wait_acc + WT_W'(best_burst);
            if (row_is_last) begin
              cnt   <= '0;
              drop  <= 1'b0;
              state <= S_LOAD;
            end else begin
              k        <= k + CNT_W'(1);
              scan_i   <= '0;
              best_vld <= 1'b0;
              state    <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase

      // running minimum; strict compare keeps the earliest of equal bursts
      if (rd_vld && !used[rd_idx] && (!best_vld || rd_burst < best_burst)) begin
        best_vld   <= 1'b1;
        best_idx   <= rd_idx;
        best_id    <= rd_id;
        best_burst <= rd_burst;
      end
    end
  end

endmodule

`default_nettype wire
